[hdl/pamn_pkg.sv]
package pamn_pkg;

   localparam int NUM_CH         = 3;
   localparam int CH_IDX_W       = $clog2(NUM_CH);
   localparam int PIX_W          = 8;
   localparam int VAL_W          = 17;
   localparam int QUOT_W         = 8;
   localparam int DIVIDEND_W     = VAL_W + QUOT_W;
   localparam int STEP_W         = $clog2(QUOT_W + 1);
   localparam int MAX_PIXELS_DEF = 4096;

   // op_mode codes
   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_PASS = 3'd4;

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   // extremes reset values
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

   typedef logic signed [VAL_W-1:0]       chan_val_type;
   typedef logic [NUM_CH-1:0][VAL_W-1:0]  pix_val_type;
   typedef logic [NUM_CH-1:0][PIX_W-1:0]  pix8_type;

   typedef struct packed {
      logic             start;
      logic             scale;   // dividend is num * 255
      logic [VAL_W-1:0] num;
      logic [VAL_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic clear;
      logic update;
   } range_ctl_type;

   // add / subtract / multiply / pass; divide goes through the shared divider
   function automatic chan_val_type combine_chan(input logic [2:0] op,
                                                 input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      logic [VAL_W-1:0]   ext_a;
      logic [VAL_W-1:0]   ext_b;
      logic [2*PIX_W-1:0] prod;
      logic [VAL_W-1:0]   res;
      ext_a = VAL_W'(a);
      ext_b = VAL_W'(b);
      prod  = a * b;
      case (op)
         OP_ADD:  res = ext_a + ext_b;
         OP_SUB:  res = ext_a - ext_b;
         OP_MUL:  res = VAL_W'(prod);
         default: res = ext_a;
      endcase
      return chan_val_type'(res);
   endfunction

endpackage

[hdl/pamn_divider.sv]
// Restoring divider, one quotient bit per cycle. Quotient must fit QUOT_W bits.
module pamn_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  pamn_pkg::div_req_type div_req,
   output pamn_pkg::div_rsp_type div_rsp
);
   import pamn_pkg::*;

   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] dsh_ff, dsh_in;
   logic [VAL_W-1:0]      den_ff, den_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] trial;
   logic                  fits;

   assign trial = rem_ff - dsh_ff;
   assign fits  = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         if (div_req.scale) begin
            // num * 255 = (num << 8) - num
            rem_in = {div_req.num, {QUOT_W{1'b0}}} - DIVIDEND_W'(div_req.num);
         end else begin
            rem_in = DIVIDEND_W'(div_req.num);
         end
         dsh_in  = DIVIDEND_W'({div_req.den, {(QUOT_W-1){1'b0}}});
         den_in  = div_req.den;
         quot_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = trial;
         end
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> busy_ff)
      else $error("divider not busy after start");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (done_ff && den_ff != '0) |-> (rem_ff < DIVIDEND_W'(den_ff)))
      else $error("divider remainder not below divisor");

endmodule

[hdl/pamn_range_track.sv]
// Running per-channel min / max of the stored values.
module pamn_range_track (
   input  logic                    clock,
   input  logic                    reset,
   input  pamn_pkg::range_ctl_type ctl,
   input  pamn_pkg::pix_val_type   val,
   output pamn_pkg::pix_val_type   hi,
   output pamn_pkg::pix_val_type   lo
);
   import pamn_pkg::*;

   pix_val_type hi_ff, hi_in;
   pix_val_type lo_ff, lo_in;

   always_comb begin
      hi_in = hi_ff;
      lo_in = lo_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         if (ctl.clear) begin
            hi_in[c] = VAL_MIN;
            lo_in[c] = VAL_MAX;
         end else if (ctl.update) begin
            if ($signed(val[c]) > $signed(hi_ff[c])) begin
               hi_in[c] = val[c];
            end
            if ($signed(val[c]) < $signed(lo_ff[c])) begin
               lo_in[c] = val[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            hi_ff[c] <= VAL_MIN;
            lo_ff[c] <= VAL_MAX;
         end
      end else begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign hi = hi_ff;
   assign lo = lo_ff;

   a_order_after_update: assert property (@(posedge clock) disable iff (reset)
      (ctl.update && !ctl.clear) |=> ($signed(lo_ff[0]) <= $signed(hi_ff[0])))
      else $error("min above max after update");

endmodule

[hdl/pixel_arith_minmax_normalize.sv]
// Load: add/sub/mul/pass combine and store before ready returns; divide instead takes
//   three passes through the shared bit-serial divider, one per channel, then stores.
// Fetch: the response follows the memory read, the offsets and the divider's three passes.
// One request at a time; a response waiting on stall does not block the next request.
// Synchronous active-high reset clears control, count, pointer, extremes, op_mode;
//   the pixel memory is not cleared.
module pixel_arith_minmax_normalize #(
   parameter int MAX_PIXELS = pamn_pkg::MAX_PIXELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic [pamn_pkg::PIX_W-1:0]  req_a_red,
   input  logic [pamn_pkg::PIX_W-1:0]  req_a_green,
   input  logic [pamn_pkg::PIX_W-1:0]  req_a_blue,
   input  logic [pamn_pkg::PIX_W-1:0]  req_b_red,
   input  logic [pamn_pkg::PIX_W-1:0]  req_b_green,
   input  logic [pamn_pkg::PIX_W-1:0]  req_b_blue,
   input  logic                        req_last_pixel,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pamn_pkg::QUOT_W-1:0] rsp_out_red,
   output logic [pamn_pkg::QUOT_W-1:0] rsp_out_green,
   output logic [pamn_pkg::QUOT_W-1:0] rsp_out_blue,
   output logic                        rsp_last_out,
   // op_mode register
   input  logic                        csr_we,
   input  logic [2:0]                  csr_wdata
);
   import pamn_pkg::*;

   localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_COMB   = 3'd1;  // add/sub/mul/pass
   localparam logic [2:0] S_LWR    = 3'd2;  // store + extremes
   localparam logic [2:0] S_FRD    = 3'd3;  // memory data back, offsets
   localparam logic [2:0] S_DSTART = 3'd4;  // kick divider for channel ch
   localparam logic [2:0] S_DWAIT  = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic [2:0]                op_mode_ff, op_mode_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          ptr_ff, ptr_in;
   logic                      frame_done_ff, frame_done_in;
   logic                      kind_ff, kind_in;       // REQ_LOAD or REQ_FETCH
   logic                      last_ff, last_in;
   logic [CH_IDX_W-1:0]       ch_ff, ch_in;
   pix8_type                  a_ff, a_in;
   pix8_type                  b_ff, b_in;
   pix_val_type               v_ff, v_in;             // combined values of a load
   pix_val_type               off_ff, off_in;         // v - min, per channel
   pix_val_type               rng_ff, rng_in;         // max - min, per channel
   pix8_type                  res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   pix8_type                  rsp_pix_ff, rsp_pix_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      accept;
   logic                      mem_rd_en;
   logic                      store_ok;
   logic                      emit_ok;
   pix_val_type               mem_rdata_ff;
   pix_val_type               pixel_mem [MAX_PIXELS];

   div_req_type               div_req;
   div_rsp_type               div_rsp;
   range_ctl_type             range_ctl;
   pix_val_type               chan_hi;
   pix_val_type               chan_lo;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign store_ok  = (count_ff < CNT_W'(MAX_PIXELS));
   assign emit_ok   = !rsp_valid_ff || !rsp_stall;
   // a fetch reads only while the frame is closed and pixels remain
   assign mem_rd_en = accept && (req_type == REQ_FETCH) && frame_done_ff
                      && (ptr_ff < count_ff);

   // ---------------- shared divider ----------------
   // Load: a / b. Fetch: (v - min) * 255 / (max - min).
   assign div_req.start = (state_ff == S_DSTART);
   assign div_req.scale = (kind_ff == REQ_FETCH);
   assign div_req.num   = (kind_ff == REQ_FETCH) ? off_ff[ch_ff] : VAL_W'(a_ff[ch_ff]);
   assign div_req.den   = (kind_ff == REQ_FETCH) ? rng_ff[ch_ff] : VAL_W'(b_ff[ch_ff]);

   pamn_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------- extremes ----------------
   // A load after the frame closed starts a new frame.
   assign range_ctl.clear  = accept && (req_type == REQ_LOAD) && frame_done_ff;
   assign range_ctl.update = (state_ff == S_LWR) && store_ok;

   pamn_range_track u_range_track (
      .clock (clock),
      .reset (reset),
      .ctl   (range_ctl),
      .val   (v_ff),
      .hi    (chan_hi),
      .lo    (chan_lo)
   );

   // ---------------- pixel memory ----------------
   always_ff @(posedge clock) begin
      if (range_ctl.update) begin
         pixel_mem[count_ff[ADDR_W-1:0]] <= v_ff;
      end
      if (mem_rd_en) begin
         mem_rdata_ff <= pixel_mem[ptr_ff[ADDR_W-1:0]];
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      op_mode_in    = op_mode_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      frame_done_in = frame_done_ff;
      kind_in       = kind_ff;
      last_in       = last_ff;
      ch_in         = ch_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      v_in          = v_ff;
      off_in        = off_ff;
      rng_in        = rng_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_pix_in    = rsp_pix_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_we) begin
         op_mode_in = csr_wdata;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in = req_type;
               ch_in   = '0;
               if (req_type == REQ_LOAD) begin
                  a_in    = {req_a_blue, req_a_green, req_a_red};
                  b_in    = {req_b_blue, req_b_green, req_b_red};
                  last_in = req_last_pixel;
                  if (frame_done_ff) begin
                     count_in      = '0;
                     ptr_in        = '0;
                     frame_done_in = 1'b0;
                  end
                  state_in = (op_mode_ff == OP_DIV) ? S_DSTART : S_COMB;
               end else if (mem_rd_en) begin
                  state_in = S_FRD;
               end
               // early or exhausted fetch: dropped, nothing changes
            end
         end

         S_COMB: begin
            for (int c = 0; c < NUM_CH; c++) begin
               v_in[c] = combine_chan(op_mode_ff, a_ff[c], b_ff[c]);
            end
            state_in = S_LWR;
         end

         S_LWR: begin
            if (store_ok) begin
               count_in = count_ff + CNT_W'(1);
            end
            // last mark closes the frame even when the pixel was dropped
            if (last_ff) begin
               frame_done_in = 1'b1;
            end
            state_in = S_IDLE;
         end

         S_FRD: begin
            for (int c = 0; c < NUM_CH; c++) begin
               off_in[c] = mem_rdata_ff[c] - chan_lo[c];
               rng_in[c] = chan_hi[c] - chan_lo[c];
            end
            state_in = S_DSTART;
         end

         S_DSTART: begin
            state_in = S_DWAIT;
         end

         S_DWAIT: begin
            if (div_rsp.done) begin
               if (kind_ff == REQ_FETCH) begin
                  // flat channel stretches to zero
                  res_in[ch_ff] = (rng_ff[ch_ff] == '0) ? '0 : div_rsp.quot;
               end else begin
                  // zero divisor passes a through
                  v_in[ch_ff] = (b_ff[ch_ff] == '0) ? VAL_W'(a_ff[ch_ff])
                                                    : VAL_W'(div_rsp.quot);
               end
               if (ch_ff == CH_IDX_W'(NUM_CH - 1)) begin
                  state_in = (kind_ff == REQ_FETCH) ? S_EMIT : S_LWR;
               end else begin
                  ch_in    = ch_ff + CH_IDX_W'(1);
                  state_in = S_DSTART;
               end
            end
         end

         S_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = res_ff;
               rsp_last_in  = (CNT_W'(ptr_ff + CNT_W'(1)) == count_ff);
               ptr_in       = ptr_ff + CNT_W'(1);
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      v_ff        <= v_in;
      off_ff      <= off_in;
      rng_ff      <= rng_in;
      res_ff      <= res_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         op_mode_ff    <= OP_ADD;
         count_ff      <= '0;
         ptr_ff        <= '0;
         frame_done_ff <= 1'b0;
         ch_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_mode_ff    <= op_mode_in;
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         frame_done_ff <= frame_done_in;
         ch_ff         <= ch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_pix_ff[0];
   assign rsp_out_green = rsp_pix_ff[1];
   assign rsp_out_blue  = rsp_pix_ff[2];
   assign rsp_last_out  = rsp_last_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT))
      else $error("response raised outside emit");

   a_ptr_in_frame: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= count_ff)
      else $error("read pointer passed pixel count");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PIXELS))
      else $error("pixel count above capacity");

endmodule

[test/pixel_arith_minmax_normalize_checker.sv]
`timescale 1ns / 100ps

module pixel_arith_minmax_normalize_checker #(
   parameter int MAX_PIX = pamn_pkg::MAX_PIXELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_type,
   input  logic [7:0] req_a_red,
   input  logic [7:0] req_a_green,
   input  logic [7:0] req_a_blue,
   input  logic [7:0] req_b_red,
   input  logic [7:0] req_b_green,
   input  logic [7:0] req_b_blue,
   input  logic       req_last_pixel,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_red,
   input  logic [7:0] rsp_out_green,
   input  logic [7:0] rsp_out_blue,
   input  logic       rsp_last_out,
   input  logic       csr_we,
   input  logic [2:0] csr_wdata,
   output int         mismatches,
   output int         results_owed
);
   import pamn_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } norm_pixel_type;

   // shadow of the frame: combined values, extremes, pointers
   chan_val_type   pix_mem [0:MAX_PIX-1][0:NUM_CH-1];
   chan_val_type   ch_hi [0:NUM_CH-1];
   chan_val_type   ch_lo [0:NUM_CH-1];
   int unsigned    pix_count;
   int unsigned    rd_ptr;
   logic           frame_closed;
   logic [2:0]     op_sel;
   norm_pixel_type owed_pixels [$];

   function automatic chan_val_type mix_chan(input logic [2:0] op, input logic [7:0] a,
                                             input logic [7:0] b);
      int ia;
      int ib;
      int r;
      ia = a;
      ib = b;
      case (op)
         OP_ADD: r = ia + ib;
         OP_SUB: r = ia - ib;
         OP_MUL: r = ia * ib;
         OP_DIV: r = (ib != 0) ? ia / ib : ia;
         default: r = ia;
      endcase
      return chan_val_type'(r);
   endfunction

   function automatic logic [7:0] stretch_chan(input chan_val_type v, input chan_val_type lo,
                                               input chan_val_type hi);
      longint span;
      longint off;
      longint q;
      span = longint'(hi) - longint'(lo);
      off  = longint'(v) - longint'(lo);
      if (span <= 0 || off <= 0) return 8'd0;
      q = (off * 255) / span;
      if (q > 255) q = 255;
      return q[7:0];
   endfunction

   function void open_frame();
      pix_count    = 0;
      rd_ptr       = 0;
      frame_closed = 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
         ch_hi[c] = VAL_MIN;
         ch_lo[c] = VAL_MAX;
      end
   endfunction

   function void check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : track_frame
      chan_val_type   v;
      pix8_type       a;
      pix8_type       b;
      norm_pixel_type want;
      if (reset) begin
         op_sel = OP_ADD;
         open_frame();
         owed_pixels.delete();
         results_owed <= 0;
      end else begin
         if (csr_we) op_sel = csr_wdata;

         if (rsp_valid && !rsp_stall) begin
            if (owed_pixels.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, actual %0d %0d %0d last %0d",
                        $time, rsp_out_red, rsp_out_green, rsp_out_blue, rsp_last_out);
               mismatches++;
            end else begin
               want = owed_pixels.pop_front();
               check_field("out_red", want.red, rsp_out_red);
               check_field("out_green", want.green, rsp_out_green);
               check_field("out_blue", want.blue, rsp_out_blue);
               check_field("last_out", {7'd0, want.last}, {7'd0, rsp_last_out});
            end
         end

         if (req_valid && !req_stall) begin
            a = {req_a_blue, req_a_green, req_a_red};
            b = {req_b_blue, req_b_green, req_b_red};
            if (req_type == REQ_LOAD) begin
               // a load after the frame closed starts a new one
               if (frame_closed) open_frame();
               if (pix_count < MAX_PIX) begin
                  for (int c = 0; c < NUM_CH; c++) begin
                     v = mix_chan(op_sel, a[c], b[c]);
                     pix_mem[pix_count][c] = v;
                     if (v > ch_hi[c]) ch_hi[c] = v;
                     if (v < ch_lo[c]) ch_lo[c] = v;
                  end
                  pix_count++;
               end
               if (req_last_pixel) frame_closed = 1'b1;
            end else if (frame_closed && rd_ptr < pix_count) begin
               want.red   = stretch_chan(pix_mem[rd_ptr][0], ch_lo[0], ch_hi[0]);
               want.green = stretch_chan(pix_mem[rd_ptr][1], ch_lo[1], ch_hi[1]);
               want.blue  = stretch_chan(pix_mem[rd_ptr][2], ch_lo[2], ch_hi[2]);
               want.last  = (rd_ptr + 1 == pix_count);
               owed_pixels.push_back(want);
               rd_ptr++;
            end
         end
         results_owed <= owed_pixels.size();
      end
   end

endmodule

[test/pixel_arith_minmax_normalize_tb.sv]
`timescale 1ns / 100ps

module pixel_arith_minmax_normalize_tb;
   import pamn_pkg::*;

   localparam int MAX_PIX     = MAX_PIXELS_DEF;
   localparam int RAND_ITEMS  = 1100;
   localparam int QUIET_TAIL  = 150;   // last stretch of random requests runs without idling
   localparam int SETTLE_CYC  = 48;    // margin for a divide load or fetch to finish inside the block
   localparam int LONG_HOLD   = 300;   // receiver hold-off long enough to back up the block
   localparam int STALL_LIMIT = 4000;  // cycles without any handshake before giving up
   localparam int HOLD_FRAME  = 4;     // random frame that gets the long receiver hold-off

   // one of the unused op codes; the block treats it as pass-through
   localparam logic [2:0] OP_SPARE = 3'd5;

   logic     clock          = 1'b0;
   logic     reset          = 1'b1;
   logic     req_valid      = 1'b0;
   logic     req_stall;
   logic     req_type       = REQ_LOAD;
   pix8_type req_a          = '0;
   pix8_type req_b          = '0;
   logic     req_last_pixel = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;
   logic       rsp_last_out;

   logic       csr_we    = 1'b0;
   logic [2:0] csr_wdata = OP_ADD;

   int mismatches;
   int results_owed;

   // idling knobs, percent chance per request / per cycle of starting a gap burst
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_request = 1'b0;

   always #5 clock = ~clock;

   pixel_arith_minmax_normalize uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_a_red      (req_a[0]),
      .req_a_green    (req_a[1]),
      .req_a_blue     (req_a[2]),
      .req_b_red      (req_b[0]),
      .req_b_green    (req_b[1]),
      .req_b_blue     (req_b[2]),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_last_out   (rsp_last_out),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   pixel_arith_minmax_normalize_checker #(
      .MAX_PIX (MAX_PIX)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_a_red      (req_a[0]),
      .req_a_green    (req_a[1]),
      .req_a_blue     (req_a[2]),
      .req_b_red      (req_b[0]),
      .req_b_green    (req_b[1]),
      .req_b_blue     (req_b[2]),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_last_out   (rsp_last_out),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .results_owed   (results_owed)
   );

   // Receiver: random stall bursts, plus one long hold-off on request from the stimulus.
   // The hold is counted here so the sender keeps offering fetches meanwhile.
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: any handshake on either channel restarts the count.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("== FAIL ==");
      $finish;
   end

   function automatic pix8_type px(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b);
      return {b, g, r};
   endfunction

   // Random channel values, leaning on 0, 1 and 255 so divide-by-zero and the
   // extremes of every op come up often.
   function automatic pix8_type rand_pix();
      pix8_type p;
      for (int c = 0; c < NUM_CH; c++) begin
         case ($urandom_range(0, 7))
            0: p[c] = 8'd0;
            1: p[c] = 8'd255;
            2: p[c] = 8'd1;
            default: p[c] = 8'($urandom);
         endcase
      end
      return p;
   endfunction

   // Drive one request and return at the edge that accepts it. Valid stays high
   // into the next request unless a gap burst comes first.
   task automatic send_req(input logic kind, input pix8_type a, input pix8_type b,
                           input logic last);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_a          <= a;
      req_b          <= b;
      req_last_pixel <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic load_rand(input logic last);
      send_req(REQ_LOAD, rand_pix(), rand_pix(), last);
   endtask

   // fetch payload is don't-care on the block side; randomize it anyway
   task automatic fetch();
      send_req(REQ_FETCH, rand_pix(), rand_pix(), 1'($urandom));
   endtask

   // Stop sending, wait for every owed response, then give the block time to
   // finish any load still grinding through the divider.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_op(input logic [2:0] mode);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned done_items;
      int unsigned len;
      int unsigned nfetch;
      int unsigned frame_no;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_idle_pct = 20;
      rsp_idle_pct = 20;

      // --- directed ---
      // add: 0 and 510 span the range; a fetch before any frame is dropped,
      // and one past the end of the frame too
      write_op(OP_ADD);
      fetch();
      send_req(REQ_LOAD, px(0, 0, 0), px(0, 0, 0), 1'b0);
      send_req(REQ_LOAD, px(255, 255, 255), px(255, 255, 255), 1'b1);
      repeat (3) fetch();
      settle();

      // subtract: negative minimum; green is flat across the frame (zero range)
      write_op(OP_SUB);
      send_req(REQ_LOAD, px(0, 128, 0), px(255, 128, 255), 1'b0);
      send_req(REQ_LOAD, px(255, 128, 255), px(0, 128, 0), 1'b1);
      repeat (2) fetch();
      settle();

      // multiply: 255 * 255 tops the value range
      write_op(OP_MUL);
      send_req(REQ_LOAD, px(255, 255, 16), px(255, 0, 16), 1'b0);
      send_req(REQ_LOAD, px(0, 255, 1), px(9, 1, 1), 1'b1);
      repeat (2) fetch();
      settle();

      // divide: zero divisor on every channel (blue included) passes a through
      write_op(OP_DIV);
      send_req(REQ_LOAD, px(200, 201, 202), px(0, 0, 0), 1'b0);
      send_req(REQ_LOAD, px(255, 7, 9), px(1, 2, 3), 1'b1);
      repeat (2) fetch();
      settle();

      // unused op code acts as pass; a one-pixel frame has zero range everywhere
      write_op(OP_SPARE);
      send_req(REQ_LOAD, px(10, 20, 30), px(1, 2, 3), 1'b1);
      repeat (2) fetch();
      settle();

      // pass: fetch on an open frame is dropped; a load in the middle of reading
      // out starts a fresh frame
      write_op(OP_PASS);
      load_rand(1'b0);
      fetch();
      load_rand(1'b1);
      fetch();
      load_rand(1'b1);
      repeat (2) fetch();
      settle();

      // --- random frames ---
      // Mostly well-formed frames read back in full, with op changes between
      // frames, a few mid-frame, early fetches, partial readouts and overreads.
      done_items = 0;
      frame_no   = 0;
      while (done_items < RAND_ITEMS) begin
         if (RAND_ITEMS - done_items < QUIET_TAIL || $urandom_range(0, 3) == 0) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = $urandom_range(10, 50);
            rsp_idle_pct = $urandom_range(10, 50);
         end

         if ($urandom_range(0, 2) == 0) begin
            settle();
            write_op(3'($urandom_range(0, 7)));
         end

         len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         if (frame_no == HOLD_FRAME) len = 30;

         for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) fetch();
            if (i > 0 && $urandom_range(0, 15) == 0) begin
               settle();
               write_op(3'($urandom_range(0, 7)));
            end
            load_rand(i == len - 1);
         end

         if ($urandom_range(0, 4) == 0) begin
            nfetch = $urandom_range(0, len);
         end else begin
            nfetch = len + $urandom_range(0, 2);
         end

         // back the block up: receiver holds off while fetches keep coming
         if (frame_no == HOLD_FRAME) begin
            nfetch       = len;
            hold_request = 1'b1;
         end

         for (int unsigned i = 0; i < nfetch; i++) fetch();
         done_items += len + ((nfetch < len) ? nfetch : len);
         frame_no++;
      end

      settle();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
